### design/prime_field_mod_alu_assert.svh
// ---------------------------------------------------------------------------
// prime_field_mod_alu assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef PRIME_FIELD_MOD_ALU_ASSERT_SVH
`define PRIME_FIELD_MOD_ALU_ASSERT_SVH

// same-cycle implication
`define PFMA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pfma_pkg.sv
// ---------------------------------------------------------------------------
// pfma_pkg
// Widths, field constants, opcodes and job types for the prime field ALU.
// ---------------------------------------------------------------------------
package pfma_pkg;

  localparam int FUNC_W = 3;
  localparam int RES_W  = 30;
  localparam int B_W    = 31;
  localparam int EXP_W  = 31;
  localparam int MULT_W = 31;
  localparam int PROD_W = 2 * MULT_W;
  localparam int RED_W  = 32;

  localparam int EXP_BITS_DEF    = 31;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [RES_W-1:0]  MODULUS    = 30'd1000000007;
  localparam logic [RED_W-1:0]  TWICE_MOD  = 32'd2000000014;
  // floor(2^60 / MODULUS)
  localparam logic [MULT_W-1:0] BARRETT_MU = 31'd1152921496;
  localparam logic [EXP_W-1:0]  FERMAT_EXP = 31'd1000000005;

  localparam logic [FUNC_W-1:0] OP_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] OP_SUB = 3'd1;
  localparam logic [FUNC_W-1:0] OP_MUL = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POW = 3'd3;
  localparam logic [FUNC_W-1:0] OP_INV = 3'd4;

  // Every operation reduces to: acc * base^expo.
  typedef struct packed {
    logic [RES_W-1:0] acc;
    logic [RES_W-1:0] base;
    logic [EXP_W-1:0] expo;
    logic             err;
  } pfma_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pfma_qstat_t;

  function automatic logic [EXP_W-1:0] exp_mask(input int bits);
    logic [EXP_W-1:0] m;
    for (int i = 0; i < EXP_W; i++) m[i] = (i < bits);
    return m;
  endfunction

endpackage

### design/pfma_front.sv
// ---------------------------------------------------------------------------
// pfma_front
// Accepts requests, checks operands, does add/subtract and turns the rest
// into exponentiation jobs for the back end.
// ---------------------------------------------------------------------------
module pfma_front import pfma_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [RES_W-1:0]  operand_a,
  input  logic [B_W-1:0]    operand_b,
  input  pfma_qstat_t       qstat,
  output logic              push,
  output pfma_job_t         push_job
);

  localparam logic [EXP_W-1:0] EMASK = exp_mask(EXP_BITS);

  logic             held;
  pfma_job_t        job;
  pfma_job_t        job_next;
  logic             a_ok;
  logic             b_ok;
  logic [B_W-1:0]   sum;
  logic [B_W-1:0]   diff;
  logic [RES_W-1:0] add_res;
  logic [RES_W-1:0] sub_res;

  assign in_stall = held && qstat.full;
  assign push     = held && !qstat.full;
  assign push_job = job;

  assign a_ok = operand_a < MODULUS;
  assign b_ok = operand_b < {1'b0, MODULUS};

  // both operands below the modulus here, so one correction suffices
  assign sum     = {1'b0, operand_a} + operand_b;
  assign add_res = (sum >= {1'b0, MODULUS}) ? RES_W'(sum - {1'b0, MODULUS}) : sum[RES_W-1:0];
  assign diff    = ({1'b0, operand_a} >= operand_b) ? {1'b0, operand_a} - operand_b
                 : {1'b0, operand_a} + {1'b0, MODULUS} - operand_b;
  assign sub_res = diff[RES_W-1:0];

  always_comb begin
    job_next.acc  = '0;
    job_next.base = operand_a;
    job_next.expo = '0;
    job_next.err  = 1'b0;
    priority if (!a_ok) begin
      job_next.err = 1'b1;
    end else begin
      unique case (func)
        OP_ADD: begin
          if (b_ok) job_next.acc = add_res;
          else      job_next.err = 1'b1;
        end
        OP_SUB: begin
          if (b_ok) job_next.acc = sub_res;
          else      job_next.err = 1'b1;
        end
        OP_MUL: begin
          if (b_ok) begin
            job_next.acc  = operand_a;
            job_next.base = operand_b[RES_W-1:0];
            job_next.expo = EXP_W'(1);
          end else begin
            job_next.err = 1'b1;
          end
        end
        OP_POW: begin
          job_next.acc  = RES_W'(1);
          job_next.expo = EXP_W'(operand_b) & EMASK;
        end
        OP_INV: begin
          if (operand_a == '0) begin
            job_next.err = 1'b1;
          end else begin
            job_next.acc  = RES_W'(1);
            job_next.expo = FERMAT_EXP;
          end
        end
        default: job_next.err = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        held <= 1'b1;
        job  <= job_next;
      end else if (push) begin
        held <= 1'b0;
      end
    end
  end

endmodule

### design/pfma_fifo.sv
// ---------------------------------------------------------------------------
// pfma_fifo
// Small register queue of jobs between the front and back ends.
// ---------------------------------------------------------------------------
module pfma_fifo import pfma_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pfma_job_t   push_job,
  input  logic        pop,
  output pfma_job_t   pop_job,
  output pfma_qstat_t qstat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pfma_job_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = count == CNT_W'(DEPTH);
  assign qstat.empty = count == '0;
  assign pop_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### design/pfma_back.sv
// ---------------------------------------------------------------------------
// pfma_back
// Square-and-multiply engine: one shared 31x31 multiplier, Barrett-reduced
// products over three multiplier passes, and the result register.
// ---------------------------------------------------------------------------
module pfma_back import pfma_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  pfma_qstat_t      qstat,
  input  pfma_job_t        pop_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [RES_W-1:0] result,
  output logic             error
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PICK = 3'd1;
  localparam logic [2:0] S_M0   = 3'd2;
  localparam logic [2:0] S_M1   = 3'd3;
  localparam logic [2:0] S_M2   = 3'd4;
  localparam logic [2:0] S_M3   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state;
  logic [RES_W-1:0]  acc;
  logic [RES_W-1:0]  base;
  logic [EXP_W-1:0]  expo;
  logic              err;
  logic              sq;        // square phase of the current exponent bit
  logic              dest_base; // product goes to base, else to acc
  logic [PROD_W-1:0] prod;
  logic [RED_W-1:0]  xlo;
  logic [MULT_W-1:0] mul_a;
  logic [MULT_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [RED_W-1:0]  rdiff;
  logic [RED_W-1:0]  rfix;

  assign pop = (state == S_IDLE) && !qstat.empty;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M0: begin
        mul_a = {1'b0, base};
        mul_b = dest_base ? {1'b0, base} : {1'b0, acc};
      end
      S_M1: begin
        mul_a = prod[2*RES_W-1:RES_W-1];
        mul_b = BARRETT_MU;
      end
      S_M2: begin
        mul_a = prod[PROD_W-1:RES_W+1];
        mul_b = {1'b0, MODULUS};
      end
      default: ;
    endcase
  end

  assign mul_p = {{(PROD_W-MULT_W){1'b0}}, mul_a} * {{(PROD_W-MULT_W){1'b0}}, mul_b};

  // Barrett estimate is short by at most two, so x - q*p < 3p fits 32 bits
  assign rdiff = xlo - prod[RED_W-1:0];
  always_comb begin
    priority if (rdiff >= TWICE_MOD)       rfix = rdiff - TWICE_MOD;
    else if (rdiff >= {2'b00, MODULUS})    rfix = rdiff - {2'b00, MODULUS};
    else                                   rfix = rdiff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // S_DONE sets out_valid itself, so the clear stays out of that state
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            acc   <= pop_job.acc;
            base  <= pop_job.base;
            expo  <= pop_job.expo;
            err   <= pop_job.err;
            sq    <= 1'b0;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          priority if (expo == '0) begin
            state <= S_DONE;
          end else if (!sq) begin
            if (expo[0]) begin
              dest_base <= 1'b0;
              state     <= S_M0;
            end else begin
              sq <= 1'b1;
            end
          end else if (expo[EXP_W-1:1] == '0) begin
            // last bit: the final square is never used
            expo <= '0;
            sq   <= 1'b0;
          end else begin
            dest_base <= 1'b1;
            state     <= S_M0;
          end
        end
        S_M0: begin
          prod  <= mul_p;
          state <= S_M1;
        end
        S_M1: begin
          xlo   <= prod[RED_W-1:0];
          prod  <= mul_p;
          state <= S_M2;
        end
        S_M2: begin
          prod  <= mul_p;
          state <= S_M3;
        end
        S_M3: begin
          if (dest_base) begin
            base <= rfix[RES_W-1:0];
            expo <= expo >> 1;
            sq   <= 1'b0;
          end else begin
            acc <= rfix[RES_W-1:0];
            sq  <= 1'b1;
          end
          state <= S_PICK;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            result    <= acc;
            error     <= err;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/prime_field_mod_alu.sv
// ---------------------------------------------------------------------------
// prime_field_mod_alu - add/sub/mul/pow/inverse modulo 1000000007
// pow/inverse run square-and-multiply over the exponent bits, each product a
// Barrett multiply on the one shared multiplier. A queue lets the front accept
// new requests while it has room and the back end works on earlier ones.
// Sync reset empties queue and output.
// ---------------------------------------------------------------------------
`include "prime_field_mod_alu_assert.svh"

module prime_field_mod_alu import pfma_pkg::*; #(
  parameter int EXP_BITS    = EXP_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [RES_W-1:0]  operand_a,
  input  logic [B_W-1:0]    operand_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RES_W-1:0]  result,
  output logic              error
);

  pfma_qstat_t qstat;
  pfma_job_t   push_job;
  pfma_job_t   pop_job;
  logic        push;
  logic        pop;

  pfma_front #(
    .EXP_BITS (EXP_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .qstat     (qstat),
    .push      (push),
    .push_job  (push_job)
  );

  pfma_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  pfma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .error     (error)
  );

  `PFMA_ASSERT_SAME(a_res_reduced, out_valid, result < MODULUS, "result not reduced")
  `PFMA_ASSERT_SAME(a_err_zero, out_valid && error, result == '0, "error with nonzero result")
  `PFMA_ASSERT_SAME(a_no_pop_empty, pop, !qstat.empty, "pop from empty queue")
  `PFMA_ASSERT_NEXT(a_push_fills, push && !pop, !qstat.empty, "queue empty after push")

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb - self-checking bench for prime_field_mod_alu
// Drives a directed table of edge cases, then randomised requests over all
// operations, and checks every transfer on the result side, field by field,
// against table values or an in-bench model of arithmetic modulo 1000000007.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfma_pkg::*;

  localparam int          EXP_BITS    = 31;
  localparam int          N_RANDOM    = 1374;
  localparam int          CALM_TAIL   = 150;
  localparam int          HOLD_CYCLES = 300;
  localparam int          FILL_ITEMS  = 16;
  localparam longint      CYCLE_LIMIT = 2000000;

  // opcodes the block does not implement
  localparam logic [FUNC_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [FUNC_W-1:0] OP_UNUSED_HI  = 3'd7;

  localparam logic [RES_W-1:0] P_M1   = MODULUS - RES_W'(1);
  localparam logic [RES_W-1:0] P_M2   = MODULUS - RES_W'(2);
  localparam logic [RES_W-1:0] A_ONES = '1;
  localparam logic [B_W-1:0]   B_ONES = '1;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             err;
  } field_out_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [RES_W-1:0]  a;
    logic [B_W-1:0]    b;
    logic              known;
    logic [RES_W-1:0]  res;
    logic              err;
  } stim_row_t;

  localparam int N_DIRECTED = 26;

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{OP_ADD, 0, 0, 1, 0, 0},
    '{OP_ADD, P_M1, P_M1, 1, P_M2, 0},
    '{OP_ADD, P_M1, 1, 1, 0, 0},
    '{OP_SUB, 0, 1, 1, P_M1, 0},
    '{OP_SUB, 0, 0, 1, 0, 0},
    '{OP_SUB, P_M1, P_M1, 1, 0, 0},
    '{OP_MUL, P_M1, P_M1, 1, 1, 0},
    '{OP_MUL, 0, P_M1, 1, 0, 0},
    '{OP_MUL, 123456789, 987654321, 0, 0, 0},
    '{OP_POW, 0, 0, 1, 1, 0},
    '{OP_POW, 0, 5, 1, 0, 0},
    '{OP_POW, 2, 10, 1, 1024, 0},
    '{OP_POW, P_M1, B_ONES, 1, P_M1, 0},
    '{OP_POW, 3, B_ONES, 0, 0, 0},
    '{OP_POW, P_M1, 31'h40000000, 1, 1, 0},
    '{OP_INV, 1, 0, 1, 1, 0},
    '{OP_INV, P_M1, B_ONES, 1, P_M1, 0},
    '{OP_INV, 2, B_ONES, 0, 0, 0},
    '{OP_INV, 0, 0, 1, 0, 1},
    '{OP_ADD, MODULUS, 0, 1, 0, 1},
    '{OP_POW, A_ONES, 0, 1, 0, 1},
    '{OP_MUL, 5, MODULUS, 1, 0, 1},
    '{OP_SUB, 0, B_ONES, 1, 0, 1},
    '{OP_UNUSED_LO, 0, 0, 1, 0, 1},
    '{OP_UNUSED_MID, 1, 1, 1, 0, 1},
    '{OP_UNUSED_HI, A_ONES, B_ONES, 1, 0, 1}
  };

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] func      = OP_ADD;
  logic [RES_W-1:0]  operand_a = '0;
  logic [B_W-1:0]    operand_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [RES_W-1:0]  result;
  logic              error;

  field_out_t pending_results [$];
  int         mismatches    = 0;
  longint     cycle_count   = 0;
  bit         calm          = 1'b0;
  int         hold_requests = 0;

  prime_field_mod_alu #(.EXP_BITS(EXP_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .error     (error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint unsigned field_mul(longint unsigned x, longint unsigned y);
    return (x * y) % longint'(MODULUS);
  endfunction

  // square-and-multiply, low bit first
  function automatic longint unsigned field_pow(longint unsigned base, longint unsigned e);
    longint unsigned acc;
    acc = 1;
    while (e != 0) begin
      if (e[0]) acc = field_mul(acc, base);
      base = field_mul(base, base);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic field_out_t field_alu_predict(logic [FUNC_W-1:0] f, logic [RES_W-1:0] a,
                                                   logic [B_W-1:0] b);
    field_out_t      r;
    longint unsigned p;
    longint unsigned emask;
    r     = '0;
    p     = longint'(MODULUS);
    emask = (64'd1 << EXP_BITS) - 1;
    if (a >= MODULUS || f > OP_INV) begin
      r.err = 1'b1;
    end else begin
      case (f)
        OP_ADD, OP_SUB, OP_MUL: begin
          if (b >= MODULUS) r.err = 1'b1;
          else if (f == OP_ADD) r.res = RES_W'((longint'(a) + longint'(b)) % p);
          else if (f == OP_SUB) r.res = RES_W'((longint'(a) + p - longint'(b)) % p);
          else r.res = RES_W'(field_mul(a, b));
        end
        OP_POW: r.res = RES_W'(field_pow(a, longint'(b) & emask));
        default: begin
          if (a == 0) r.err = 1'b1;
          else r.res = RES_W'(field_pow(a, longint'(FERMAT_EXP)));
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_request(logic [FUNC_W-1:0] f, logic [RES_W-1:0] a, logic [B_W-1:0] b,
                              field_out_t want);
    int gap;
    gap = (!calm && $urandom_range(4, 0) == 0) ? $urandom_range(6, 1) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    func      <= f;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(want);
  endtask

  // drop valid first so the last request is not offered twice
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side back-pressure; a long hold is counted here on request
  always @(negedge clk) begin
    int hold_seen;
    int hold_left;
    int stall_left;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(7, 0) == 0) begin
      stall_left = $urandom_range(6, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    field_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer, result %0d error %0b", $time, result, error);
      end else begin
        want = pending_results.pop_front();
        if (result !== want.res) begin
          mismatches++;
          $display("%0t: result expected %0d actual %0d", $time, want.res, result);
        end
        if (error !== want.err) begin
          mismatches++;
          $display("%0t: error expected %0b actual %0b", $time, want.err, error);
        end
      end
    end
  end

  initial begin
    logic [FUNC_W-1:0] f;
    logic [RES_W-1:0]  a;
    logic [B_W-1:0]    b;
    int                kind;
    int                fsel;
    field_out_t        want;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].known) want = '{directed_rows[i].res, directed_rows[i].err};
      else want = field_alu_predict(directed_rows[i].func, directed_rows[i].a, directed_rows[i].b);
      send_request(directed_rows[i].func, directed_rows[i].a, directed_rows[i].b, want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (N_RANDOM - n) < CALM_TAIL;

      fsel = $urandom_range(99, 0);
      if (fsel < 22) f = OP_ADD;
      else if (fsel < 44) f = OP_SUB;
      else if (fsel < 66) f = OP_MUL;
      else if (fsel < 88) f = OP_POW;
      else f = OP_INV;

      if ($urandom_range(9, 0) == 0) begin
        case ($urandom_range(2, 0))
          0: a = '0;
          1: a = RES_W'(1);
          default: a = P_M1;
        endcase
      end else begin
        a = RES_W'($urandom_range(P_M1, 0));
      end

      if (f == OP_POW) begin
        // short exponents keep half the powers quick, long ones reach every bit
        b = $urandom_range(1, 0) ? B_W'($urandom) : B_W'($urandom_range(63, 0));
      end else if (f == OP_INV) begin
        b = B_W'($urandom);
      end else if ($urandom_range(9, 0) == 0) begin
        b = $urandom_range(1, 0) ? B_W'(P_M1) : B_W'(0);
      end else begin
        b = B_W'($urandom_range(P_M1, 0));
      end

      kind = $urandom_range(99, 0);
      if (kind < 4) begin
        f = FUNC_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        a = RES_W'($urandom);
        b = B_W'($urandom);
      end else if (kind < 8) begin
        a = RES_W'($urandom_range(A_ONES, MODULUS));
      end else if (kind < 12) begin
        f = FUNC_W'($urandom_range(OP_MUL, OP_ADD));
        b = B_W'($urandom_range(B_ONES, MODULUS));
      end

      // fast requests while the result side is held off, to fill the block
      if (n == 300) hold_requests++;
      if (n >= 300 && n < 300 + FILL_ITEMS) begin
        f = OP_ADD;
        a = RES_W'($urandom_range(P_M1, 0));
        b = B_W'($urandom_range(P_M1, 0));
      end

      if (n == 700) wait_results_drained();

      send_request(f, a, b, field_alu_predict(f, a, b));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_results_drained();
    repeat (400) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### prime_field_mod_alu.f
+incdir+design
design/pfma_pkg.sv
design/pfma_front.sv
design/pfma_fifo.sv
design/pfma_back.sv
design/prime_field_mod_alu.sv
tb/tb.sv
